// ===== hdl/isfp_pkg.sv =====
// ----------------------------------------------------------------------------
// isfp_pkg
// Shared constants and types for the IMU serial frame parser.
// ----------------------------------------------------------------------------
package isfp_pkg;

  // Default number of 16-bit sample words in a type A2 frame
  localparam int PAYLOAD_WORDS_DEF = 12;

  // Frame framing bytes
  localparam logic [7:0] HDR0        = 8'hAE;
  localparam logic [7:0] HDR1        = 8'hEA;
  localparam logic [7:0] TRL0        = 8'hEF;
  localparam logic [7:0] TRL1        = 8'hFE;
  localparam logic [7:0] TYPE_SAMPLE = 8'hA2;
  localparam logic [7:0] MIN_LEN     = 8'd7;

  // Header bytes pre-summed into the running checksum
  localparam logic [7:0] HDR_SUM = 8'(HDR0 + HDR1);

  // Result kinds
  typedef enum logic [1:0] {
    KIND_WORD  = 2'd0,
    KIND_CSUM  = 2'd1,
    KIND_SHORT = 2'd2
  } kind_t;

  // Frame-done event from the parser to the result sequencer
  typedef struct packed {
    logic  fire;
    kind_t kind;
  } frame_done_t;

endpackage

// ===== hdl/imu_serial_frame_parser.sv =====
// ----------------------------------------------------------------------------
// imu_serial_frame_parser
// Serial IMU frame parser: header hunt, checksum and trailer check, word output.
// ----------------------------------------------------------------------------
// One received byte is taken per cycle while the parser hunts for a header or
// reads the length. Payload bytes are written pairwise into a word store as
// they arrive. A frame that ends with a good trailer gives one error result
// (bad checksum, short A2 frame), PAYLOAD_WORDS sample words (full A2 frame)
// or nothing (other types). Sample words are read from the store one word per
// cycle into the output register while the sink keeps out_ready high. While a
// frame drains, header and length bytes are still taken, but frame body bytes
// wait until the last result of the previous frame has been issued.
module imu_serial_frame_parser #(
  parameter int PAYLOAD_WORDS = isfp_pkg::PAYLOAD_WORDS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [7:0]         rx_byte,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         kind,
  output logic [3:0]         word_index,
  output logic signed [15:0] word_value,
  output logic               last
);
  import isfp_pkg::*;

  localparam int AW = (PAYLOAD_WORDS > 1) ? $clog2(PAYLOAD_WORDS) : 1;

  frame_done_t   done;
  logic          busy;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [15:0]   ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [15:0]   ram_rdata;
  kind_t         kind_q;

  isfp_frame_fsm #(
    .PAYLOAD_WORDS(PAYLOAD_WORDS),
    .AW           (AW)
  ) u_fsm (
    .clk      (clk),
    .rst      (rst),
    .rx_byte  (rx_byte),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .busy     (busy),
    .ram_we   (ram_we),
    .ram_waddr(ram_waddr),
    .ram_wdata(ram_wdata),
    .done     (done)
  );

  isfp_payload_ram #(
    .DEPTH(PAYLOAD_WORDS),
    .AW   (AW)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  isfp_result_ctrl #(
    .PAYLOAD_WORDS(PAYLOAD_WORDS),
    .AW           (AW)
  ) u_res (
    .clk       (clk),
    .rst       (rst),
    .done      (done),
    .busy      (busy),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .kind      (kind_q),
    .word_index(word_index),
    .last      (last)
  );

  // Error kinds carry a zero value
  assign kind       = kind_q;
  assign word_value = (kind_q == KIND_WORD) ? $signed(ram_rdata) : 16'sd0;

endmodule

// ===== hdl/isfp_payload_ram.sv =====
// ----------------------------------------------------------------------------
// isfp_payload_ram
// Payload word store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module isfp_payload_ram #(
  parameter int DEPTH = isfp_pkg::PAYLOAD_WORDS_DEF,
  parameter int AW    = 4
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [15:0]   wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [15:0]   rdata
);

  logic [15:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/isfp_frame_fsm.sv =====
// ----------------------------------------------------------------------------
// isfp_frame_fsm
// Header hunt, length capture, checksum and trailer check, payload writes.
// ----------------------------------------------------------------------------
module isfp_frame_fsm #(
  parameter int PAYLOAD_WORDS = isfp_pkg::PAYLOAD_WORDS_DEF,
  parameter int AW            = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [7:0]            rx_byte,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  busy,
  output logic                  ram_we,
  output logic [AW-1:0]         ram_waddr,
  output logic [15:0]           ram_wdata,
  output isfp_pkg::frame_done_t done
);
  import isfp_pkg::*;

  localparam logic [7:0] PAY_BYTES = 8'(2 * PAYLOAD_WORDS);
  localparam logic [7:0] FULL_LEN  = 8'(7 + 2 * PAYLOAD_WORDS);

  typedef enum logic [3:0] {
    PH_HUNT0 = 4'b0001,
    PH_HUNT1 = 4'b0010,
    PH_LEN   = 4'b0100,
    PH_BODY  = 4'b1000
  } phase_t;

  phase_t     phase, phase_next;
  logic [7:0] frame_length, frame_length_next;
  logic [7:0] byte_position, byte_position_next;
  logic [7:0] running_sum, running_sum_next;
  logic [7:0] frame_type, frame_type_next;
  logic [7:0] received_checksum, received_checksum_next;
  logic [7:0] trailer_first, trailer_first_next;
  logic [7:0] hi_byte;

  logic       accept;
  logic [7:0] sum_upd;
  logic [7:0] pay_off;
  logic       in_payload;
  logic       at_end;
  logic       trailer_ok;
  logic       sum_ok;

  // Body bytes wait while a finished frame is still being read out
  assign in_ready = !((phase == PH_BODY) && busy);
  assign accept   = in_valid && in_ready;

  assign sum_upd    = running_sum + rx_byte;
  assign pay_off    = byte_position - 8'd4;
  assign in_payload = (byte_position >= 8'd4) && (pay_off < PAY_BYTES);
  assign at_end     = (byte_position >= frame_length - 8'd1);
  assign trailer_ok = (trailer_first == TRL0) && (rx_byte == TRL1);
  assign sum_ok     = (sum_upd == received_checksum);

  // Payload store: high byte held, full word written on the low byte
  assign ram_we    = accept && (phase == PH_BODY) && in_payload && pay_off[0];
  assign ram_waddr = pay_off[AW:1];
  assign ram_wdata = {hi_byte, rx_byte};

  always_ff @(posedge clk) begin
    if (accept && (phase == PH_BODY) && in_payload && !pay_off[0]) begin
      hi_byte <= rx_byte;
    end
  end

  // Frame completion event
  always_comb begin
    done.fire = 1'b0;
    done.kind = KIND_WORD;
    if (accept && (phase == PH_BODY) && at_end && trailer_ok) begin
      if (!sum_ok) begin
        done.fire = 1'b1;
        done.kind = KIND_CSUM;
      end else if (frame_type == TYPE_SAMPLE) begin
        done.fire = 1'b1;
        done.kind = (frame_length < FULL_LEN) ? KIND_SHORT : KIND_WORD;
      end
    end
  end

  // Parser next state
  always_comb begin
    phase_next             = phase;
    frame_length_next      = frame_length;
    byte_position_next     = byte_position;
    running_sum_next       = running_sum;
    frame_type_next        = frame_type;
    received_checksum_next = received_checksum;
    trailer_first_next     = trailer_first;
    if (accept) begin
      unique case (phase)
        PH_HUNT0: begin
          if (rx_byte == HDR0) phase_next = PH_HUNT1;
        end
        PH_HUNT1: begin
          if (rx_byte == HDR1) begin
            phase_next = PH_LEN;
          end else if (rx_byte != HDR0) begin
            phase_next = PH_HUNT0;
          end
        end
        PH_LEN: begin
          if (rx_byte < MIN_LEN) begin
            phase_next = PH_HUNT0;
          end else begin
            frame_length_next  = rx_byte;
            running_sum_next   = HDR_SUM + rx_byte;
            byte_position_next = 8'd3;
            phase_next         = PH_BODY;
          end
        end
        PH_BODY: begin
          if (byte_position == 8'd3) frame_type_next = rx_byte;
          if (byte_position == frame_length - 8'd3) begin
            received_checksum_next = rx_byte;
          end else begin
            running_sum_next = sum_upd;
          end
          if (byte_position == frame_length - 8'd2) trailer_first_next = rx_byte;
          if (at_end) begin
            phase_next = PH_HUNT0;
          end else begin
            byte_position_next = byte_position + 8'd1;
          end
        end
        default: phase_next = PH_HUNT0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_HUNT0;
      frame_length      <= '0;
      byte_position     <= '0;
      running_sum       <= '0;
      frame_type        <= '0;
      received_checksum <= '0;
      trailer_first     <= '0;
    end else begin
      phase             <= phase_next;
      frame_length      <= frame_length_next;
      byte_position     <= byte_position_next;
      running_sum       <= running_sum_next;
      frame_type        <= frame_type_next;
      received_checksum <= received_checksum_next;
      trailer_first     <= trailer_first_next;
    end
  end

endmodule

// ===== hdl/isfp_result_ctrl.sv =====
// ----------------------------------------------------------------------------
// isfp_result_ctrl
// Issues frame results into the result register, walking the payload store for sample words.
// ----------------------------------------------------------------------------
module isfp_result_ctrl #(
  parameter int PAYLOAD_WORDS = isfp_pkg::PAYLOAD_WORDS_DEF,
  parameter int AW            = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  isfp_pkg::frame_done_t done,
  output logic                  busy,
  output logic                  ram_re,
  output logic [AW-1:0]         ram_raddr,
  output logic                  out_valid,
  input  logic                  out_ready,
  output isfp_pkg::kind_t       kind,
  output logic [3:0]            word_index,
  output logic                  last
);
  import isfp_pkg::*;

  localparam logic [3:0] LAST_IDX = 4'(PAYLOAD_WORDS - 1);

  kind_t      job_kind;
  logic [3:0] idx;
  logic       issue;
  logic       issue_last;

  // Issue one result while a job is pending and the output register is free or draining
  assign issue      = busy && (!out_valid || out_ready);
  assign issue_last = (job_kind != KIND_WORD) || (idx == LAST_IDX);
  assign ram_re     = issue && (job_kind == KIND_WORD);
  assign ram_raddr  = idx[AW-1:0];

  // Job sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      idx      <= '0;
      job_kind <= KIND_WORD;
    end else if (done.fire) begin
      busy     <= 1'b1;
      idx      <= '0;
      job_kind <= done.kind;
    end else if (issue) begin
      idx <= idx + 4'd1;
      if (issue_last) busy <= 1'b0;
    end
  end

  // Output register; the word value comes from the store's read register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (issue) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      kind       <= job_kind;
      word_index <= (job_kind == KIND_WORD) ? idx : 4'd0;
      last       <= issue_last;
    end
  end

endmodule

// ===== hdl/isfp_checker.sv =====
// ----------------------------------------------------------------------------
// isfp_checker
// Port-level checks on the result channel of the frame parser.
// ----------------------------------------------------------------------------
module isfp_checker #(
  parameter int PAYLOAD_WORDS = isfp_pkg::PAYLOAD_WORDS_DEF
) (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input logic [1:0]         kind,
  input logic [3:0]         word_index,
  input logic signed [15:0] word_value,
  input logic               last
);
  import isfp_pkg::*;

  // A stalled result holds its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=>
      out_valid && $stable(kind) && $stable(word_index) && $stable(word_value)
      && $stable(last))
    else $error("result changed while stalled");

  // Error results are single, final and zero-valued
  a_err: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == KIND_CSUM || kind == KIND_SHORT) |->
      last && (word_index == 4'd0) && (word_value == 16'sd0))
    else $error("malformed error result");

  // Sample word index stays in range and last marks the final word
  a_idx: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == KIND_WORD) |->
      (word_index < 4'(PAYLOAD_WORDS))
      && (last == (word_index == 4'(PAYLOAD_WORDS - 1))))
    else $error("bad sample word index or last flag");

  // A non-final sample word is followed by the next index
  a_seq: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && (kind == KIND_WORD) && !last ##1 out_valid |->
      (kind == KIND_WORD) && (word_index == $past(word_index) + 4'd1))
    else $error("sample words out of order");

endmodule

bind imu_serial_frame_parser isfp_checker #(
  .PAYLOAD_WORDS(PAYLOAD_WORDS)
) u_isfp_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .kind      (kind),
  .word_index(word_index),
  .word_value(word_value),
  .last      (last)
);
